// ===== sv/hjs_pkg.sv =====
// ============================================================================
// hjs_pkg
// Shared types and constants of the heat Jacobi stencil sweep unit.
// ============================================================================
package hjs_pkg;

	// Grid size default: rows and columns run from 0 to GRID_LAST_DEF
	localparam int GRID_LAST_DEF = 63;

	// Field widths
	localparam int FUNC_W  = 2;
	localparam int COORD_W = 6;
	localparam int TEMP_W  = 32;
	localparam int COEF_W  = 18;
	localparam int RES_W   = 64;
	localparam int CNT_W   = 17;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	// Shared multiplier operand and product widths
	localparam int MUL_IN_W  = 34;
	localparam int MUL_OUT_W = 2 * MUL_IN_W;

	// Function codes of an input transaction
	localparam logic [FUNC_W-1:0] FN_WRITE = 2'd0;
	localparam logic [FUNC_W-1:0] FN_SWEEP = 2'd1;
	localparam logic [FUNC_W-1:0] FN_READ  = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BETA   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAXSW  = 3'd4;

	// Register reset values
	localparam logic [COEF_W-1:0] ALPHA_RST  = 18'd0;
	localparam logic [COEF_W-1:0] BETA_RST   = 18'd16384;
	localparam logic [TEMP_W-1:0] SOURCE_RST = 32'd82;
	localparam logic [RES_W-1:0]  LIMIT_RST  = 64'd0;
	localparam logic [CNT_W-1:0]  MAXSW_RST  = 17'd100000;

	// Sweep counter saturates here
	localparam logic [CNT_W-1:0] COUNT_MAX = 17'h1FFFF;

	// Shared multiplier operations
	typedef enum logic [1:0] {
		OP_SELF,   // alpha * center cell
		OP_NEIGH,  // beta * neighbor sum
		OP_SQ      // change squared
	} alu_op_t;

	typedef struct packed {
		logic    en;
		alu_op_t op;
	} alu_ctl_t;

endpackage

// ===== sv/hjs_ram.sv =====
// ============================================================================
// hjs_ram
// Generic RAM: one write port, two read ports, registered read data.
// ============================================================================
module hjs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr0,
	input  logic [$clog2(DEPTH)-1:0] raddr1,
	output logic [WIDTH-1:0]         rdata0,
	output logic [WIDTH-1:0]         rdata1
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered reads
	always_ff @(posedge clk) begin
		rdata0 <= mem_q[raddr0];
		rdata1 <= mem_q[raddr1];
	end

endmodule

// ===== sv/hjs_alu.sv =====
// ============================================================================
// hjs_alu
// Shared signed multiplier with operand selection and a registered product.
// ============================================================================
module hjs_alu (
	input  logic                                    clk,
	input  hjs_pkg::alu_ctl_t                       ctl,
	input  logic signed [hjs_pkg::TEMP_W-1:0]       cell_val,
	input  logic signed [hjs_pkg::MUL_IN_W-1:0]     nsum,
	input  logic signed [hjs_pkg::TEMP_W:0]         diff,
	input  logic signed [hjs_pkg::COEF_W-1:0]       alpha,
	input  logic signed [hjs_pkg::COEF_W-1:0]       beta,
	output logic signed [hjs_pkg::MUL_OUT_W-1:0]    prod
);

	localparam int CPAD = hjs_pkg::MUL_IN_W - hjs_pkg::TEMP_W;
	localparam int KPAD = hjs_pkg::MUL_IN_W - hjs_pkg::COEF_W;
	localparam int DPAD = hjs_pkg::MUL_IN_W - hjs_pkg::TEMP_W - 1;

	logic signed [hjs_pkg::MUL_IN_W-1:0] op_a;
	logic signed [hjs_pkg::MUL_IN_W-1:0] op_b;

	// Operand select
	always_comb begin
		case (ctl.op)
			hjs_pkg::OP_NEIGH: begin
				op_a = nsum;
				op_b = {{KPAD{beta[hjs_pkg::COEF_W-1]}}, beta};
			end
			hjs_pkg::OP_SQ: begin
				op_a = {{DPAD{diff[hjs_pkg::TEMP_W]}}, diff};
				op_b = {{DPAD{diff[hjs_pkg::TEMP_W]}}, diff};
			end
			default: begin
				op_a = {{CPAD{cell_val[hjs_pkg::TEMP_W-1]}}, cell_val};
				op_b = {{KPAD{alpha[hjs_pkg::COEF_W-1]}}, alpha};
			end
		endcase
	end

	// Product register
	always_ff @(posedge clk) begin
		if (ctl.en) begin
			prod <= op_a * op_b;
		end
	end

endmodule

// ===== sv/heat_jacobi_stencil_sweep_unit.sv =====
// ============================================================================
// heat_jacobi_stencil_sweep_unit
// Square temperature grid with cell write/read and explicit five-point
// Jacobi sweeps of the heat equation, reporting residual and sweep status.
// ============================================================================
//
//  channel  handshake              payload
//  -------  ---------------------  ------------------------------------------
//  in       in_valid / in_stall    func, row, col, value
//  out      out_valid / out_stall  cell_value, residual_sq, finished,
//                                  sweeps_done
//  cfg      cfg_we                 cfg_idx, cfg_wdata
//
//  After reset the grid memories are zeroed, one entry per cycle, through all
//  2**(2*ceil(log2(GRID_LAST+1))) entries (4096 at the default); no
//  transaction is taken meanwhile. In a sweep every interior cell passes
//  through the one shared multiplier three times and the two-port grid
//  memory twice. One transaction is worked at a time; a finished result waits
//  in the output register while the next transaction is taken.
// ============================================================================
module heat_jacobi_stencil_sweep_unit #(
	parameter int GRID_LAST = hjs_pkg::GRID_LAST_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration
	input  logic                                  cfg_we,
	input  logic [hjs_pkg::CFG_IDX_W-1:0]         cfg_idx,
	input  logic [hjs_pkg::CFG_DATA_W-1:0]        cfg_wdata,
	// input channel
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [hjs_pkg::FUNC_W-1:0]            func,
	input  logic [hjs_pkg::COORD_W-1:0]           row,
	input  logic [hjs_pkg::COORD_W-1:0]           col,
	input  logic signed [hjs_pkg::TEMP_W-1:0]     value,
	// output channel
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [hjs_pkg::TEMP_W-1:0]     cell_value,
	output logic [hjs_pkg::RES_W-1:0]             residual_sq,
	output logic                                  finished,
	output logic [hjs_pkg::CNT_W-1:0]             sweeps_done
);

	localparam int SW    = $clog2(GRID_LAST + 1);
	localparam int AW    = 2 * SW;
	localparam int DEPTH = 2 ** AW;
	localparam int TW    = hjs_pkg::TEMP_W;
	localparam int MW    = hjs_pkg::MUL_IN_W;
	localparam int PW    = hjs_pkg::MUL_OUT_W;
	localparam int RW    = hjs_pkg::RES_W;

	localparam logic [SW-1:0] IN_LAST = SW'(GRID_LAST - 1);
	localparam logic [SW-1:0] ONE     = SW'(1);
	localparam logic [SW-1:0] ZERO    = SW'(0);

	localparam logic signed [51:0] S32_MAX = 52'sd2147483647;
	localparam logic signed [51:0] S32_MIN = -52'sd2147483648;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_READ, S_ROW, S_RD0, S_RD1, S_MA, S_MB,
		S_AD, S_DF, S_SQ, S_AC, S_FIN, S_DONE
	} state_t;

	// Saturate a wide signed value to 32 bits
	function automatic logic signed [TW-1:0] sat32(input logic signed [51:0] v);
		logic signed [TW-1:0] r;
		if (v > S32_MAX) begin
			r = S32_MAX[TW-1:0];
		end else if (v < S32_MIN) begin
			r = S32_MIN[TW-1:0];
		end else begin
			r = v[TW-1:0];
		end
		return r;
	endfunction

	state_t state_q;

	// configuration registers
	logic signed [hjs_pkg::COEF_W-1:0] alpha_q;
	logic signed [hjs_pkg::COEF_W-1:0] beta_q;
	logic signed [TW-1:0]              source_q;
	logic [RW-1:0]                     limit_q;
	logic [hjs_pkg::CNT_W-1:0]         maxsw_q;

	// status
	logic [RW-1:0]             resid_q;
	logic [hjs_pkg::CNT_W-1:0] count_q;
	logic                      done_q;

	// sequencer and datapath registers
	logic [AW-1:0]        clr_q;
	logic                 sel_q;      // 1: buffer B holds the current grid
	logic                 rd_in_q;
	logic [SW-1:0]        i_q;
	logic [SW-1:0]        j_q;
	logic signed [TW-1:0] w_q, c_q, e_q, n_q, s_q;
	logic signed [MW-1:0] nsum_q;
	logic signed [TW-1:0] p1_q;
	logic signed [TW-1:0] new_q;
	logic signed [TW:0]   d_q;
	logic [RW-1:0]        acc_q;
	logic signed [TW-1:0] cell_q;

	// memory ports
	logic          we_a, we_b;
	logic [AW-1:0] waddr;
	logic [TW-1:0] wdata;
	logic [AW-1:0] raddr0, raddr1;
	logic [TW-1:0] a_rd0, a_rd1, b_rd0, b_rd1;
	logic signed [TW-1:0] rd0, rd1;

	// shared multiplier
	hjs_pkg::alu_ctl_t     alu_ctl;
	logic signed [PW-1:0]  prod;

	// item decode
	logic          in_acc;
	logic          on_grid;
	logic [AW-1:0] item_addr;

	// arithmetic helpers
	logic signed [TW-1:0]   p2;
	logic signed [TW+1:0]   sum3;
	logic signed [MW-1:0]   nsum;
	logic [RW:0]            acc_sum;
	logic [hjs_pkg::CNT_W-1:0] count_nx;

	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign on_grid   = (32'(row) <= 32'(GRID_LAST)) && (32'(col) <= 32'(GRID_LAST));
	assign item_addr = {SW'(row), SW'(col)};

	assign rd0 = sel_q ? b_rd0 : a_rd0;
	assign rd1 = sel_q ? b_rd1 : a_rd1;

	// Write port steering: clear pass, cell write to both buffers, sweep to next
	always_comb begin
		we_a  = 1'b0;
		we_b  = 1'b0;
		waddr = item_addr;
		wdata = value;
		case (state_q)
			S_CLEAR: begin
				we_a  = 1'b1;
				we_b  = 1'b1;
				waddr = clr_q;
				wdata = '0;
			end
			S_IDLE: begin
				we_a = in_acc && (func == hjs_pkg::FN_WRITE) && on_grid;
				we_b = in_acc && (func == hjs_pkg::FN_WRITE) && on_grid;
			end
			S_DF: begin
				we_a  = sel_q;
				we_b  = !sel_q;
				waddr = {i_q, j_q};
				wdata = new_q;
			end
			default: begin
				we_a = 1'b0;
				we_b = 1'b0;
			end
		endcase
	end

	// Read address steering
	always_comb begin
		raddr0 = item_addr;
		raddr1 = item_addr;
		case (state_q)
			S_ROW: begin
				raddr0 = {i_q, ZERO};
				raddr1 = {i_q, ONE};
			end
			S_RD0: begin
				raddr0 = {i_q - ONE, j_q};
				raddr1 = {i_q + ONE, j_q};
			end
			S_RD1: begin
				raddr0 = {i_q, j_q + ONE};
			end
			default: begin
				raddr0 = item_addr;
				raddr1 = item_addr;
			end
		endcase
	end

	// Multiplier control
	always_comb begin
		alu_ctl.en = 1'b0;
		alu_ctl.op = hjs_pkg::OP_SELF;
		case (state_q)
			S_MA: begin
				alu_ctl.en = 1'b1;
				alu_ctl.op = hjs_pkg::OP_SELF;
			end
			S_MB: begin
				alu_ctl.en = 1'b1;
				alu_ctl.op = hjs_pkg::OP_NEIGH;
			end
			S_SQ: begin
				alu_ctl.en = 1'b1;
				alu_ctl.op = hjs_pkg::OP_SQ;
			end
			default: begin
				alu_ctl.en = 1'b0;
			end
		endcase
	end

	// Neighbor sum, new value, residual accumulate, next count
	assign nsum = {{(MW-TW){n_q[TW-1]}}, n_q} + {{(MW-TW){s_q[TW-1]}}, s_q}
	            + {{(MW-TW){w_q[TW-1]}}, w_q} + {{(MW-TW){rd0[TW-1]}}, rd0};
	assign p2   = sat32(prod[67:16]);
	assign sum3 = {{2{p1_q[TW-1]}}, p1_q} + {{2{p2[TW-1]}}, p2}
	            + {{2{source_q[TW-1]}}, source_q};
	assign acc_sum  = {1'b0, acc_q} + {1'b0, prod[RW-1:0]};
	assign count_nx = (count_q == hjs_pkg::COUNT_MAX) ? count_q : count_q + 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q  <= hjs_pkg::ALPHA_RST;
			beta_q   <= hjs_pkg::BETA_RST;
			source_q <= hjs_pkg::SOURCE_RST;
			limit_q  <= hjs_pkg::LIMIT_RST;
			maxsw_q  <= hjs_pkg::MAXSW_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				hjs_pkg::REG_ALPHA:  alpha_q  <= cfg_wdata[hjs_pkg::COEF_W-1:0];
				hjs_pkg::REG_BETA:   beta_q   <= cfg_wdata[hjs_pkg::COEF_W-1:0];
				hjs_pkg::REG_SOURCE: source_q <= cfg_wdata[TW-1:0];
				hjs_pkg::REG_LIMIT:  limit_q  <= cfg_wdata[RW-1:0];
				hjs_pkg::REG_MAXSW:  maxsw_q  <= cfg_wdata[hjs_pkg::CNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Sequencer, datapath registers and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			sel_q       <= 1'b0;
			rd_in_q     <= 1'b0;
			i_q         <= ONE;
			j_q         <= ONE;
			w_q         <= '0;
			c_q         <= '0;
			e_q         <= '0;
			n_q         <= '0;
			s_q         <= '0;
			nsum_q      <= '0;
			p1_q        <= '0;
			new_q       <= '0;
			d_q         <= '0;
			acc_q       <= '0;
			cell_q      <= '0;
			resid_q     <= '0;
			count_q     <= '0;
			done_q      <= 1'b0;
			out_valid   <= 1'b0;
			cell_value  <= '0;
			residual_sq <= '0;
			finished    <= 1'b0;
			sweeps_done <= '0;
		end else begin
			// result taken; S_DONE loads the register itself
			if (out_valid && !out_stall && (state_q != S_DONE)) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				// zero both grid buffers
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == {AW{1'b1}}) begin
						state_q <= S_IDLE;
					end
				end
				// take one transaction
				S_IDLE: begin
					if (in_acc) begin
						case (func)
							hjs_pkg::FN_WRITE: begin
								cell_q  <= value;
								state_q <= S_DONE;
							end
							hjs_pkg::FN_READ: begin
								rd_in_q <= on_grid;
								state_q <= S_READ;
							end
							hjs_pkg::FN_SWEEP: begin
								cell_q  <= '0;
								i_q     <= ONE;
								j_q     <= ONE;
								acc_q   <= '0;
								state_q <= done_q ? S_DONE : S_ROW;
							end
							default: begin
								cell_q  <= '0;
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_READ: begin
					cell_q  <= rd_in_q ? rd0 : '0;
					state_q <= S_DONE;
				end
				// row start: west and center reads issued
				S_ROW: begin
					state_q <= S_RD0;
				end
				S_RD0: begin
					if (j_q == ONE) begin
						w_q <= rd0;
						c_q <= rd1;
					end
					state_q <= S_RD1;
				end
				S_RD1: begin
					n_q     <= rd0;
					s_q     <= rd1;
					state_q <= S_MA;
				end
				// east arrives; alpha * center in the multiplier
				S_MA: begin
					e_q     <= rd0;
					nsum_q  <= nsum;
					state_q <= S_MB;
				end
				S_MB: begin
					p1_q    <= sat32(prod[67:16]);
					state_q <= S_AD;
				end
				S_AD: begin
					new_q   <= sat32({{18{sum3[TW+1]}}, sum3});
					state_q <= S_DF;
				end
				// new value written to the next buffer
				S_DF: begin
					d_q     <= {new_q[TW-1], new_q} - {c_q[TW-1], c_q};
					state_q <= S_SQ;
				end
				S_SQ: begin
					state_q <= S_AC;
				end
				// accumulate, slide the window, step to next cell
				S_AC: begin
					acc_q <= acc_sum[RW] ? {RW{1'b1}} : acc_sum[RW-1:0];
					w_q   <= c_q;
					c_q   <= e_q;
					if (j_q == IN_LAST) begin
						j_q <= ONE;
						if (i_q == IN_LAST) begin
							state_q <= S_FIN;
						end else begin
							i_q     <= i_q + ONE;
							state_q <= S_ROW;
						end
					end else begin
						j_q     <= j_q + ONE;
						state_q <= S_RD0;
					end
				end
				// swap buffers and update status
				S_FIN: begin
					sel_q   <= !sel_q;
					resid_q <= acc_q;
					count_q <= count_nx;
					done_q  <= (acc_q <= limit_q) || (count_nx >= maxsw_q);
					state_q <= S_DONE;
				end
				// load the result register once it is free
				S_DONE: begin
					if (!out_valid || !out_stall) begin
						out_valid   <= 1'b1;
						cell_value  <= cell_q;
						residual_sq <= resid_q;
						finished    <= done_q;
						sweeps_done <= count_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	hjs_ram #(
		.WIDTH(TW),
		.DEPTH(DEPTH)
	) u_grid_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (waddr),
		.wdata (wdata),
		.raddr0(raddr0),
		.raddr1(raddr1),
		.rdata0(a_rd0),
		.rdata1(a_rd1)
	);

	hjs_ram #(
		.WIDTH(TW),
		.DEPTH(DEPTH)
	) u_grid_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (waddr),
		.wdata (wdata),
		.raddr0(raddr0),
		.raddr1(raddr1),
		.rdata0(b_rd0),
		.rdata1(b_rd1)
	);

	hjs_alu u_alu (
		.clk     (clk),
		.ctl     (alu_ctl),
		.cell_val(c_q),
		.nsum    (nsum_q),
		.diff    (d_q),
		.alpha   (alpha_q),
		.beta    (beta_q),
		.prod    (prod)
	);

endmodule

// ===== bench/heat_jacobi_stencil_sweep_unit_tb.sv =====
// ============================================================================
// heat_jacobi_stencil_sweep_unit_tb
// Self-checking bench for the heat Jacobi stencil sweep unit. Drives cell
// writes, reads, sweeps and unused codes under random idling and stalls. A
// grid tracker class keeps its own copy of the temperature grid and of the
// registers, predicts every result and checks each returned transaction
// field by field.
// ============================================================================
`timescale 1ns / 1ps

module heat_jacobi_stencil_sweep_unit_tb;

	localparam int GRID_LAST   = hjs_pkg::GRID_LAST_DEF;
	localparam int GRID_SIDE   = GRID_LAST + 1;
	localparam int GRID_CELLS  = GRID_SIDE * GRID_SIDE;
	localparam int QUIET_LIMIT = 150000;
	localparam int SWEEP_BUDGET = 14;
	localparam int HOLD_CYCLES = 300;
	localparam int FW = hjs_pkg::FUNC_W;
	localparam int CW = hjs_pkg::COORD_W;
	localparam int TW = hjs_pkg::TEMP_W;
	localparam int RW = hjs_pkg::RES_W;
	localparam int NW = hjs_pkg::CNT_W;
	localparam int KW = hjs_pkg::COEF_W;
	localparam int IW = hjs_pkg::CFG_IDX_W;
	localparam int DW = hjs_pkg::CFG_DATA_W;
	localparam logic [FW-1:0] FN_UNUSED = 2'd3;
	localparam longint TEMP_MAX = (longint'(1) <<< 31) - 1;
	localparam longint TEMP_MIN = -(longint'(1) <<< 31);

	typedef struct {
		logic signed [TW-1:0] cval;
		logic [RW-1:0]        resid;
		logic                 fin;
		logic [NW-1:0]        count;
	} grid_status_t;

	// Grid and status tracker: predicts each result and checks the returned one
	class grid_status_tracker;
		logic signed [TW-1:0] temps [GRID_CELLS];
		logic signed [TW-1:0] staged [GRID_CELLS];
		logic signed [KW-1:0] alpha;
		logic signed [KW-1:0] beta;
		logic signed [TW-1:0] source;
		logic [RW-1:0]        limit;
		logic [NW-1:0]        max_sw;
		logic [RW-1:0]        last_resid;
		logic [NW-1:0]        sweep_count;
		bit                   done;
		grid_status_t         pending_status [$];
		int                   mismatches;

		function new();
			foreach (temps[k]) begin
				temps[k] = '0;
				staged[k] = '0;
			end
			alpha = hjs_pkg::ALPHA_RST;
			beta = hjs_pkg::BETA_RST;
			source = hjs_pkg::SOURCE_RST;
			limit = hjs_pkg::LIMIT_RST;
			max_sw = hjs_pkg::MAXSW_RST;
			last_resid = '0;
			sweep_count = '0;
			done = 0;
			mismatches = 0;
		endfunction

		function void set_reg(logic [IW-1:0] idx, logic [DW-1:0] data);
			case (idx)
				hjs_pkg::REG_ALPHA:  alpha = data[KW-1:0];
				hjs_pkg::REG_BETA:   beta = data[KW-1:0];
				hjs_pkg::REG_SOURCE: source = data[TW-1:0];
				hjs_pkg::REG_LIMIT:  limit = data[RW-1:0];
				hjs_pkg::REG_MAXSW:  max_sw = data[NW-1:0];
				default: ;
			endcase
		endfunction

		static function longint clamp32(longint x);
			if (x > TEMP_MAX)
				return TEMP_MAX;
			if (x < TEMP_MIN)
				return TEMP_MIN;
			return x;
		endfunction

		// One explicit five-point update of the interior, old grid read throughout
		function void apply_sweep();
			longint nsum, p1, p2, d;
			longint unsigned mag, sq, acc;
			int i, j, k;
			acc = 0;
			for (i = 1; i < GRID_LAST; i++)
				for (j = 1; j < GRID_LAST; j++) begin
					k = i * GRID_SIDE + j;
					nsum = longint'(temps[k + GRID_SIDE]) + longint'(temps[k - GRID_SIDE])
						+ longint'(temps[k + 1]) + longint'(temps[k - 1]);
					// arithmetic shift floors toward minus infinity
					p1 = clamp32((longint'(alpha) * longint'(temps[k])) >>> 16);
					p2 = clamp32((longint'(beta) * nsum) >>> 16);
					staged[k] = TW'(clamp32(p1 + p2 + longint'(source)));
				end
			// summed squared change, saturating per term and in the sum
			for (i = 1; i < GRID_LAST; i++)
				for (j = 1; j < GRID_LAST; j++) begin
					k = i * GRID_SIDE + j;
					d = longint'(staged[k]) - longint'(temps[k]);
					mag = (d < 0) ? -d : d;
					sq = (mag >= 64'h1_0000_0000) ? '1 : mag * mag;
					acc = (acc > ~sq) ? '1 : acc + sq;
				end
			for (i = 1; i < GRID_LAST; i++)
				for (j = 1; j < GRID_LAST; j++)
					temps[i * GRID_SIDE + j] = staged[i * GRID_SIDE + j];
			last_resid = acc;
			if (sweep_count != hjs_pkg::COUNT_MAX)
				sweep_count++;
			if (last_resid <= limit || sweep_count >= max_sw)
				done = 1;
		endfunction

		function void take_item(logic [FW-1:0] f, logic [CW-1:0] r,
				logic [CW-1:0] c, logic signed [TW-1:0] v);
			grid_status_t want;
			int idx;
			bit on_grid;
			idx = int'(r) * GRID_SIDE + int'(c);
			on_grid = (int'(r) <= GRID_LAST) && (int'(c) <= GRID_LAST);
			want.cval = '0;
			case (f)
				hjs_pkg::FN_WRITE: begin
					if (on_grid)
						temps[idx] = v;
					want.cval = v;
				end
				hjs_pkg::FN_SWEEP: if (!done)
					apply_sweep();
				hjs_pkg::FN_READ: if (on_grid)
					want.cval = temps[idx];
				default: ;
			endcase
			want.resid = last_resid;
			want.fin = done;
			want.count = sweep_count;
			pending_status.push_back(want);
		endfunction

		function void match_status(logic signed [TW-1:0] cval, logic [RW-1:0] resid,
				logic fin, logic [NW-1:0] count);
			grid_status_t want;
			if (pending_status.size() == 0) begin
				$error("result with no transaction pending: cell_value %0d", cval);
				mismatches++;
				return;
			end
			want = pending_status.pop_front();
			if (cval !== want.cval) begin
				$error("cell_value: expected %0d, got %0d", want.cval, cval);
				mismatches++;
			end
			if (resid !== want.resid) begin
				$error("residual_sq: expected %h, got %h", want.resid, resid);
				mismatches++;
			end
			if (fin !== want.fin) begin
				$error("finished: expected %0b, got %0b", want.fin, fin);
				mismatches++;
			end
			if (count !== want.count) begin
				$error("sweeps_done: expected %0d, got %0d", want.count, count);
				mismatches++;
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [IW-1:0]        cfg_idx;
	logic [DW-1:0]        cfg_wdata;
	logic                 in_valid;
	logic                 in_stall;
	logic [FW-1:0]        func;
	logic [CW-1:0]        row;
	logic [CW-1:0]        col;
	logic signed [TW-1:0] value;
	logic                 out_valid;
	logic                 out_stall;
	logic signed [TW-1:0] cell_value;
	logic [RW-1:0]        residual_sq;
	logic                 finished;
	logic [NW-1:0]        sweeps_done;

	grid_status_tracker board = new();
	bit tx_steady = 0;
	bit rx_steady = 0;
	bit rx_hold_req = 0;
	int quiet_cycles = 0;

	heat_jacobi_stencil_sweep_unit #(
		.GRID_LAST(GRID_LAST)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.func(func),
		.row(row),
		.col(col),
		.value(value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cell_value(cell_value),
		.residual_sq(residual_sq),
		.finished(finished),
		.sweeps_done(sweeps_done)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// Result side: random stalls, calm stretches and one long hold-off
	initial begin : result_sink
		int hold_left;
		hold_left = 0;
		out_stall = 0;
		forever begin
			@(negedge clk);
			if (rx_hold_req) begin
				hold_left = HOLD_CYCLES;
				rx_hold_req = 0;
			end
			if (hold_left > 0) begin
				out_stall = 1;
				hold_left--;
			end else if (rx_steady)
				out_stall = 0;
			else
				out_stall = ($urandom_range(99) < 33);
		end
	end

	// Check every accepted result transaction
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.match_status(cell_value, residual_sq, finished, sweeps_done);
	end

	// Watchdog on cycles with no transaction on either channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("** heat_jacobi_stencil_sweep_unit: FAILED **");
			$finish;
		end
	end

	task automatic offer(input logic [FW-1:0] f, input logic [CW-1:0] r,
			input logic [CW-1:0] c, input logic [TW-1:0] v);
		while (!tx_steady && $urandom_range(99) < 33)
			@(negedge clk) in_valid = 0;
		@(negedge clk);
		func = f;
		row = r;
		col = c;
		value = v;
		in_valid = 1;
		do @(posedge clk); while (in_stall);
		board.take_item(f, r, c, v);
	endtask

	task automatic write_reg(input logic [IW-1:0] idx, input logic [DW-1:0] data);
		@(negedge clk);
		cfg_we = 1;
		cfg_idx = idx;
		cfg_wdata = data;
		@(negedge clk) cfg_we = 0;
		board.set_reg(idx, data);
	endtask

	// Stop offering and wait for every predicted result to come back
	task automatic drain_results();
		@(negedge clk) in_valid = 0;
		while (board.pending_status.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Coordinates biased to the boundary and its neighbors
	function automatic logic [CW-1:0] pick_coord();
		case ($urandom_range(3))
			0: return CW'(GRID_LAST * $urandom_range(1));
			1: return $urandom_range(1) ? CW'(1) : CW'(GRID_LAST - 1);
			default: return CW'($urandom_range(GRID_LAST));
		endcase
	endfunction

	function automatic logic [TW-1:0] pick_temp();
		case ($urandom_range(9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2, 3, 4: return $urandom_range(20 * 65536) - 10 * 65536;
			default: return $urandom;
		endcase
	endfunction

	initial begin : stimulus
		int ph, n, b, a, s, pick, sweeps_sent;
		logic [CW-1:0] r, c, wr_r, wr_c;
		logic [TW-1:0] v;
		sweeps_sent = 0;
		wr_r = 1;
		wr_c = 1;
		func = hjs_pkg::FN_WRITE;
		row = '0;
		col = '0;
		value = '0;
		in_valid = 0;
		cfg_we = 0;
		cfg_idx = hjs_pkg::REG_ALPHA;
		cfg_wdata = '0;
		arst_n = 0;
		repeat (8) @(posedge clk);
		@(negedge clk) arst_n = 1;

		// Directed: grid corners, value extremes, unwritten read, unused code
		offer(hjs_pkg::FN_WRITE, 0, 0, 32'h7FFF_FFFF);
		offer(hjs_pkg::FN_WRITE, GRID_LAST, GRID_LAST, 32'h8000_0000);
		offer(hjs_pkg::FN_WRITE, 0, GRID_LAST, 32'hFFFF_FFFF);
		offer(hjs_pkg::FN_WRITE, GRID_LAST, 0, 32'h0000_0001);
		offer(hjs_pkg::FN_READ, 30, 30, 32'hFFFF_FFFF);
		offer(hjs_pkg::FN_WRITE, 1, 1, 32'h7FFF_FFFF);
		offer(hjs_pkg::FN_WRITE, 1, 2, 32'h7FFF_FFFF);
		offer(hjs_pkg::FN_WRITE, 2, 1, 32'h7FFF_FFFF);
		offer(hjs_pkg::FN_WRITE, GRID_LAST - 1, GRID_LAST - 1, 32'h8000_0000);
		offer(hjs_pkg::FN_WRITE, GRID_LAST - 1, GRID_LAST - 2, 32'h8000_0000);
		offer(FN_UNUSED, GRID_LAST, GRID_LAST, 32'h5555_AAAA);
		offer(hjs_pkg::FN_READ, 0, 0, 32'h0);
		offer(hjs_pkg::FN_READ, GRID_LAST, GRID_LAST, 32'h0);
		offer(hjs_pkg::FN_READ, 0, GRID_LAST, 32'h0);
		offer(hjs_pkg::FN_SWEEP, 0, 0, 32'h0);
		offer(hjs_pkg::FN_READ, 1, 1, 32'h0);
		offer(hjs_pkg::FN_READ, 2, 2, 32'h0);
		offer(hjs_pkg::FN_READ, GRID_LAST - 1, GRID_LAST - 1, 32'h0);
		offer(hjs_pkg::FN_READ, 0, 0, 32'h0);
		offer(hjs_pkg::FN_SWEEP, 0, 0, 32'h0);
		offer(hjs_pkg::FN_READ, 31, 31, 32'h0);

		// Largest coefficients and source: products saturate high
		drain_results();
		write_reg(hjs_pkg::REG_ALPHA, 131071);
		write_reg(hjs_pkg::REG_BETA, 131071);
		write_reg(hjs_pkg::REG_SOURCE, 32'h7FFF_FFFF);
		write_reg(hjs_pkg::REG_LIMIT, 0);
		write_reg(hjs_pkg::REG_MAXSW, 131071);
		offer(hjs_pkg::FN_WRITE, 5, 5, 32'h7FFF_FFFF);
		offer(hjs_pkg::FN_WRITE, 5, 6, 32'h8000_0000);
		offer(hjs_pkg::FN_SWEEP, 0, 0, 32'h0);
		offer(hjs_pkg::FN_READ, 5, 5, 32'h0);
		offer(hjs_pkg::FN_READ, 4, 5, 32'h0);

		// Most negative coefficients and source: products saturate low
		drain_results();
		write_reg(hjs_pkg::REG_ALPHA, -131072);
		write_reg(hjs_pkg::REG_BETA, -131072);
		write_reg(hjs_pkg::REG_SOURCE, 64'hFFFF_FFFF_8000_0000);
		offer(hjs_pkg::FN_WRITE, 7, 7, 32'h8000_0000);
		offer(hjs_pkg::FN_SWEEP, 0, 0, 32'h0);
		offer(hjs_pkg::FN_READ, 7, 7, 32'h0);
		offer(hjs_pkg::FN_READ, 7, 8, 32'h0);

		// Random phases: physical coefficients alternate with arbitrary ones
		for (ph = 0; ph < 4; ph++) begin
			drain_results();
			if (ph % 2 == 0) begin
				b = $urandom_range(16384);
				a = 65536 - 4 * b + $urandom_range(64) - 32;
				s = $urandom_range(131072) - 65536;
				write_reg(hjs_pkg::REG_BETA, b);
				write_reg(hjs_pkg::REG_ALPHA, a);
				write_reg(hjs_pkg::REG_SOURCE, s);
				write_reg(hjs_pkg::REG_LIMIT, (ph == 0) ? 64'd0 : {32'h0, $urandom});
			end else begin
				write_reg(hjs_pkg::REG_ALPHA, {$urandom, $urandom});
				write_reg(hjs_pkg::REG_BETA, {$urandom, $urandom});
				write_reg(hjs_pkg::REG_SOURCE, {$urandom, $urandom});
				write_reg(hjs_pkg::REG_LIMIT, 0);
			end
			write_reg(hjs_pkg::REG_MAXSW, $urandom_range(131071, 1000));
			if (ph == 1) begin
				rx_hold_req = 1;
				tx_steady = 1;
			end
			if (ph == 2) begin
				tx_steady = 1;
				rx_steady = 1;
			end
			for (n = 0; n < 25; n++) begin
				if (ph == 1 && n == 10)
					tx_steady = 0;
				if (ph == 3 && n == 12)
					drain_results();
				pick = $urandom_range(99);
				r = pick_coord();
				c = pick_coord();
				v = pick_temp();
				if (pick < 12 && sweeps_sent < SWEEP_BUDGET) begin
					sweeps_sent++;
					offer(hjs_pkg::FN_SWEEP, r, c, v);
				end else if (pick < 55) begin
					wr_r = r;
					wr_c = c;
					offer(hjs_pkg::FN_WRITE, r, c, v);
				end else if (pick < 92) begin
					if ($urandom_range(1))
						offer(hjs_pkg::FN_READ, wr_r, wr_c, v);
					else
						offer(hjs_pkg::FN_READ, r, c, v);
				end else
					offer(FN_UNUSED, r, c, v);
			end
			tx_steady = 0;
			rx_steady = 0;
		end

		// Zero sweep limit: next sweep finishes, later sweeps change nothing
		drain_results();
		write_reg(hjs_pkg::REG_MAXSW, 0);
		offer(hjs_pkg::FN_WRITE, 10, 10, pick_temp());
		offer(hjs_pkg::FN_SWEEP, 0, 0, 32'h0);
		offer(hjs_pkg::FN_READ, 10, 10, 32'h0);
		offer(hjs_pkg::FN_SWEEP, 0, 0, 32'h0);
		offer(hjs_pkg::FN_WRITE, 20, 20, 32'h1234_5678);
		offer(hjs_pkg::FN_READ, 20, 20, 32'h0);
		offer(hjs_pkg::FN_SWEEP, 0, 0, 32'h0);
		offer(hjs_pkg::FN_READ, 20, 20, 32'h0);
		offer(FN_UNUSED, 20, 20, 32'hFFFF_FFFF);

		// Widest limit and lowest sweep count after finish
		drain_results();
		write_reg(hjs_pkg::REG_LIMIT, '1);
		write_reg(hjs_pkg::REG_MAXSW, 1);
		write_reg(hjs_pkg::REG_ALPHA, 65536);
		write_reg(hjs_pkg::REG_SOURCE, 0);
		offer(hjs_pkg::FN_SWEEP, 0, 0, 32'h0);
		offer(hjs_pkg::FN_READ, 10, 10, 32'h0);

		drain_results();
		repeat (40) @(posedge clk);
		if (board.pending_status.size() != 0) begin
			$error("%0d results never arrived", board.pending_status.size());
			board.mismatches++;
		end
		if (board.mismatches == 0)
			$display("** heat_jacobi_stencil_sweep_unit: PASSED **");
		else
			$display("** heat_jacobi_stencil_sweep_unit: FAILED **");
		$finish;
	end

endmodule

// ===== files.f =====
sv/hjs_pkg.sv
sv/hjs_ram.sv
sv/hjs_alu.sv
sv/heat_jacobi_stencil_sweep_unit.sv
bench/heat_jacobi_stencil_sweep_unit_tb.sv
